FILE: rtl/sc2a_pkg.sv
package sc2a_pkg;

  localparam int FIFO_DEPTH_DEF = 256;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CODE_LCTRL     = 8'h1D;
  localparam logic [7:0] CODE_LCTRL_BRK = 8'h9D;
  localparam logic [7:0] CODE_S         = 8'h1F;
  localparam logic [7:0] CODE_X         = 8'h2D;
  localparam logic [7:0] TABLE_LEN      = 8'd58;

  localparam logic [6:0] ASCII_CTRL_S = 7'h13;
  localparam logic [6:0] ASCII_CTRL_X = 7'h18;

  // unshifted set-1 map, padded to 64 entries with zeros
  localparam logic [6:0] KEY_TABLE [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef struct packed {
    logic       op;
    logic [7:0] scancode;
  } key_beat_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       char_valid;
    logic       has_data;
    logic       dropped;
  } chr_beat_t;

endpackage

FILE: rtl/sc2a_ram.sv
module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/scancode_to_ascii_fifo.sv
// channel  dir  handshake              payload
// key      in   key_valid / key_ready  key_data (op, scancode)
// chr      out  chr_valid / chr_ready  chr_data (char_out, char_valid, has_data, dropped)
//
// one beat per cycle sustained while chr is not stalled; each key beat passes the read stage,
// where the memory data arrives, and then the output register before it is a chr beat
// sync reset clears pointers, ctrl flag and valids; the character memory is not cleared
// a stalled chr side holds one result in the output register and one in the read stage,
// then key_ready drops
module scancode_to_ascii_fifo
  import sc2a_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      key_valid,
  output logic      key_ready,
  input  key_beat_t key_data,
  output logic      chr_valid,
  input  logic      chr_ready,
  output chr_beat_t chr_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_inc, wr_ptr_inc;
  logic             ctrl_held, ctrl_held_next;

  logic             accept;
  logic             empty;
  logic             in_table;
  logic [6:0]       key_char;
  logic [6:0]       push_char;
  logic             ram_we, ram_re;
  logic [6:0]       ram_rdata;

  logic             rd_valid;
  chr_beat_t        rd_beat, rd_beat_next;
  chr_beat_t        out_beat;
  logic             rd_move;

  assign rd_move   = rd_valid && (!chr_valid || chr_ready);
  assign key_ready = !rd_valid || rd_move;
  assign accept    = key_valid && key_ready;

  assign empty      = rd_ptr == wr_ptr;
  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);

  assign in_table = !key_data.scancode[7] && (key_data.scancode < TABLE_LEN);
  assign key_char = KEY_TABLE[key_data.scancode[5:0]];

  always_comb begin
    push_char = key_char;
    if (ctrl_held) begin
      if (key_data.scancode == CODE_S) begin
        push_char = ASCII_CTRL_S;
      end else if (key_data.scancode == CODE_X) begin
        push_char = ASCII_CTRL_X;
      end else begin
        push_char = '0;
      end
    end
  end

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    ctrl_held_next = ctrl_held;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    rd_beat_next   = '0;
    if (accept) begin
      if (key_data.op == OP_READ) begin
        if (!empty) begin
          ram_re                  = 1'b1;
          rd_ptr_next             = rd_ptr_inc;
          rd_beat_next.char_valid = 1'b1;
        end
      end else if (key_data.scancode == CODE_LCTRL) begin
        ctrl_held_next = 1'b1;
      end else if (key_data.scancode == CODE_LCTRL_BRK) begin
        ctrl_held_next = 1'b0;
      end else if (in_table && push_char != '0) begin
        if (wr_ptr_inc == rd_ptr) begin
          rd_beat_next.dropped = 1'b1;
        end else begin
          ram_we      = 1'b1;
          wr_ptr_next = wr_ptr_inc;
        end
      end
    end
    rd_beat_next.has_data = rd_ptr_next != wr_ptr_next;
  end

  sc2a_ram #(
    .WIDTH(7),
    .DEPTH(FIFO_DEPTH)
  ) u_char_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(push_char),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      ctrl_held <= 1'b0;
    end else begin
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      ctrl_held <= ctrl_held_next;
    end
  end

  // read stage: memory data arrives here
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (accept) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_beat <= rd_beat_next;
    end
  end

  always_comb begin
    out_beat          = rd_beat;
    out_beat.char_out = rd_beat.char_valid ? ram_rdata : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (rd_move) begin
      chr_valid <= 1'b1;
    end else if (chr_ready) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      chr_data <= out_beat;
    end
  end

endmodule

FILE: verif/tb_scancode_to_ascii_fifo.sv
module tb_scancode_to_ascii_fifo;
  import sc2a_pkg::*;

  localparam int          FIFO_SLOTS   = FIFO_DEPTH_DEF - 1;
  localparam logic [7:0]  RELEASE_MASK = 8'h80;

  // unshifted set-1 map, make codes 0 to 57
  localparam logic [6:0] unshifted_ascii [58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20
  };

  class key_fifo_scoreboard;
    logic [6:0] held_chars[$];
    bit         ctrl_down;
    chr_beat_t  results_due[$];
    int         errors;

    function void note_key(key_beat_t k);
      chr_beat_t  r;
      logic [6:0] c;
      bit         keep;
      r = '0;
      if (k.op == OP_READ) begin
        if (held_chars.size() != 0) begin
          r.char_out   = held_chars.pop_front();
          r.char_valid = 1'b1;
        end
      end else if (k.scancode == CODE_LCTRL) begin
        ctrl_down = 1'b1;
      end else if (k.scancode == CODE_LCTRL_BRK) begin
        ctrl_down = 1'b0;
      end else if (k.scancode < TABLE_LEN) begin
        c = unshifted_ascii[k.scancode];
        keep = 1'b1;
        if (ctrl_down) begin
          if (k.scancode == CODE_S) c = ASCII_CTRL_S;
          else if (k.scancode == CODE_X) c = ASCII_CTRL_X;
          else keep = 1'b0;
        end
        if (keep && c != 7'h00) begin
          if (held_chars.size() == FIFO_SLOTS) r.dropped = 1'b1;
          else held_chars.push_back(c);
        end
      end
      r.has_data = (held_chars.size() != 0);
      results_due.push_back(r);
    endfunction

    function void check_char(chr_beat_t got);
      chr_beat_t want;
      if (results_due.size() == 0) begin
        $error("chr beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.char_out !== want.char_out) begin
        $error("char_out expected %h actual %h", want.char_out, got.char_out);
        errors++;
      end
      if (got.char_valid !== want.char_valid) begin
        $error("char_valid expected %b actual %b", want.char_valid, got.char_valid);
        errors++;
      end
      if (got.has_data !== want.has_data) begin
        $error("has_data expected %b actual %b", want.has_data, got.has_data);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped expected %b actual %b", want.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      key_valid;
  logic      key_ready;
  key_beat_t key_data;
  logic      chr_valid;
  logic      chr_ready;
  chr_beat_t chr_data;

  key_fifo_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  int keys_sent;

  scancode_to_ascii_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_data  (key_data),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_data  (chr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (key_valid && key_ready) sb.note_key(key_data);
      if (chr_valid && chr_ready) sb.check_char(chr_data);
    end
  end

  // receiver side, long hold-off counted here
  initial begin
    chr_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        chr_ready = 1'b0;
        stall_left--;
      end else begin
        chr_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_key(input logic op, input logic [7:0] code);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid = 1'b0;
      @(negedge clk);
    end
    key_valid = 1'b1;
    key_data.op = op;
    key_data.scancode = code;
    do @(posedge clk); while (!key_ready);
    keys_sent++;
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    @(negedge clk);
    key_valid = 1'b0;
    while (sb.results_due.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.results_due.size() != 0) begin
      $error("%0d chr beats never arrived", sb.results_due.size());
      sb.errors++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic type_keys();
    int n;
    logic [7:0] code;
    n = $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(99) < 85) code = 8'($urandom_range(57));
      else code = 8'($urandom_range(58, 127));
      send_key(OP_SCAN, code);
      if ($urandom_range(99) < 70) send_key(OP_SCAN, code | RELEASE_MASK);
      if ($urandom_range(99) < 40) send_key(OP_READ, 8'($urandom));
    end
  endtask

  task automatic ctrl_combo();
    int n;
    logic [7:0] code;
    send_key(OP_SCAN, CODE_LCTRL);
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(3))
        0: code = CODE_S;
        1: code = CODE_X;
        2: code = 8'($urandom_range(127));
        default: code = CODE_LCTRL;
      endcase
      send_key(OP_SCAN, code);
      if ($urandom_range(1) == 1) send_key(OP_SCAN, code | RELEASE_MASK);
      if ($urandom_range(1) == 1) send_key(OP_READ, 8'($urandom));
    end
    if ($urandom_range(99) < 85) send_key(OP_SCAN, CODE_LCTRL_BRK);
  endtask

  task automatic run_random(input int upto);
    while (keys_sent < upto) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: type_keys();
        5: ctrl_combo();
        6, 7: repeat ($urandom_range(1, 15)) send_key(OP_READ, 8'($urandom));
        default: repeat ($urandom_range(1, 10)) send_key(1'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // push past the last free slot, then read everything back and beyond
  task automatic fill_past_full();
    logic [7:0] code;
    send_key(OP_SCAN, CODE_LCTRL_BRK);
    repeat (FIFO_DEPTH_DEF + 3) begin
      do code = 8'($urandom_range(57)); while (unshifted_ascii[code] == 7'h00);
      send_key(OP_SCAN, code);
    end
    repeat (FIFO_DEPTH_DEF + 2) send_key(OP_READ, 8'($urandom));
  endtask

  initial begin
    sb = new;
    rst = 1'b1;
    key_valid = 1'b0;
    key_data = '0;
    send_idle_pct = 8;
    recv_idle_pct = 74;
    stall_left = 0;
    keys_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    send_key(OP_READ, 8'hFF);
    send_key(OP_SCAN, 8'h00);
    send_key(OP_SCAN, 8'd57);
    send_key(OP_SCAN, 8'd58);
    send_key(OP_SCAN, 8'h7F);
    send_key(OP_SCAN, 8'h80);
    send_key(OP_SCAN, 8'hFF);
    send_key(OP_SCAN, 8'h02);
    send_key(OP_SCAN, CODE_LCTRL);
    send_key(OP_SCAN, CODE_S);
    send_key(OP_SCAN, CODE_X);
    send_key(OP_SCAN, 8'h1E);
    send_key(OP_SCAN, 8'd58);
    send_key(OP_SCAN, CODE_S | RELEASE_MASK);
    send_key(OP_SCAN, CODE_LCTRL_BRK);
    send_key(OP_SCAN, CODE_S);
    send_key(OP_SCAN, 8'h1C);
    repeat (7) send_key(OP_READ, 8'h00);
    wait_drain();

    run_random(350);
    wait_drain();

    send_idle_pct = 74;
    recv_idle_pct = 8;
    run_random(600);
    wait_drain();

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 300;
    run_random(730);
    fill_past_full();
    wait_drain();

    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
